FILE: sv/ntca_pkg.sv
// ---------------------------------------------------------------------------
// ntca_pkg
// Shared types, field widths and constants of the NTC temperature averager.
// ---------------------------------------------------------------------------
`default_nettype none

package ntca_pkg;

    localparam int CODE_W  = 12;
    localparam int RES_W   = 20;
    localparam int BETA_W  = 14;
    localparam int T0_W    = 16;
    localparam int TEMP_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam int PROD_W  = 32;
    localparam int LN_W    = 28;   // table entries, Q28
    localparam int LNS_W   = 34;   // ln of a 32-bit value, Q28
    localparam int DIV_N   = 52;   // dividend / quotient width
    localparam int DIV_M   = 48;   // divisor width

    localparam logic [CODE_W-1:0] FULL_CODE = 12'hFFF;
    localparam logic [52:0] ZERO_C_Q = 53'd437040;   // 273.15 K in 1/1600 K

    localparam logic [TEMP_W-1:0] TEMP_MIN = 16'h8000;
    localparam logic [TEMP_W-1:0] TEMP_MAX = 16'h7FFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SERIES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_T0      = 2'd3;

    typedef enum logic [3:0] {
        DP_IDLE, DP_LOAD, DP_CHECK, DP_NORM, DP_LN, DP_LNDIFF, DP_DBETA, DP_DT0,
        DP_INV, DP_DQ, DP_DC, DP_TEMP, DP_ACCUM, DP_DAVG, DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   div_start;
    } dp_cmd_t;

    typedef struct packed {
        logic bad_in;
        logic norm_done;
        logic inv_bad;
        logic div_done;
        logic group_full;
        logic out_free;
    } dp_sts_t;

    // Truncated Q31 series 2*atanh(z), rounded to Q28; z is elaboration constant.
    function automatic logic [LN_W-1:0] ln_series(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] s;
        logic [63:0] p;
        logic        stop;
        z2   = (z * z) >> 31;
        s    = z;
        p    = z;
        stop = 1'b0;
        for (int k = 3; k < 200; k += 2) begin
            if (!stop) begin
                p = (p * z2) >> 31;
                if (p == 64'd0) begin
                    stop = 1'b1;
                end else begin
                    s = s + p / 64'(k);
                end
            end
        end
        return LN_W'((64'd2 * s + 64'd4) >> 3);
    endfunction

endpackage

`default_nettype wire

FILE: sv/ntca_div.sv
// ---------------------------------------------------------------------------
// ntca_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ntca_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [ntca_pkg::DIV_N-1:0]  dividend,
    input  wire logic [ntca_pkg::DIV_M-1:0]  divisor,
    output logic      [ntca_pkg::DIV_N-1:0]  quotient,
    output logic                             done
);
    import ntca_pkg::*;

    localparam int CNT_W = $clog2(DIV_N + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_M:0]    rem_reg;
    logic [DIV_N-1:0]  quo_reg;
    logic [DIV_M-1:0]  dvs_reg;
    logic              done_reg;

    logic [DIV_M:0]    rem_sh;
    logic [DIV_M+1:0]  trial;

    assign rem_sh = {rem_reg[DIV_M-1:0], quo_reg[DIV_N-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_N);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                // subtract where the trial remainder stays non-negative
                if (!trial[DIV_M+1]) begin
                    rem_reg <= trial[DIV_M:0];
                end else begin
                    rem_reg <= rem_sh;
                end
                quo_reg <= {quo_reg[DIV_N-2:0], ~trial[DIV_M+1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

FILE: sv/ntca_datapath.sv
// ---------------------------------------------------------------------------
// ntca_datapath
// Configuration registers, resistance products, ln lookup, Beta equation,
// group accumulator and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ntca_datapath #(
    parameter int AVG_COUNT      = 5,
    parameter int LN_TABLE_DEPTH = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire ntca_pkg::dp_cmd_t                cmd,
    output ntca_pkg::dp_sts_t                     sts,
    input  wire logic [ntca_pkg::CODE_W-1:0]      s_adc_code,
    input  wire logic                             cfg_valid,
    input  wire logic [ntca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ntca_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [ntca_pkg::TEMP_W-1:0]    m_average_temp,
    output logic                                  m_range_error
);
    import ntca_pkg::*;

    localparam int LG    = $clog2(LN_TABLE_DEPTH);
    localparam int CNT_W = $clog2(AVG_COUNT + 1);
    localparam int SUM_W = 17 + $clog2(AVG_COUNT);

    // divide by 100 as a reciprocal multiply; exact below 2^22
    localparam int               RECIP100_SH = 29;
    localparam logic [22:0]      RECIP100    = 23'd5368710;

    // divide by the group length as a reciprocal multiply; exact below 2^SUM_W
    localparam int               AVG_SH    = SUM_W + 4;
    localparam int               AVG_PW    = SUM_W + AVG_SH + 1;
    localparam logic [AVG_SH:0]  AVG_RECIP = (AVG_SH + 1)'(
        ((64'd1 << AVG_SH) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));

    // ln(1 + i/DEPTH) table, built at elaboration
    logic [LN_W-1:0] ln_rom [0:LN_TABLE_DEPTH];
    for (genvar g = 0; g <= LN_TABLE_DEPTH; g++) begin : g_tab
        localparam logic [63:0] ZG =
            (64'(g) << 31) / (64'(2 * LN_TABLE_DEPTH) + 64'(g));
        assign ln_rom[g] = ln_series(ZG);
    end

    logic [RES_W-1:0]  rs_reg, rn_reg;
    logic [BETA_W-1:0] beta_reg;
    logic [T0_W-1:0]   t0_reg;

    logic [CODE_W-1:0] code_reg;
    logic [PROD_W-1:0] num_reg, den_reg;
    logic [4:0]        ns_reg, ds_reg;
    logic [LN_W-1:0]   fn_reg, fd_reg;
    logic              lnr_neg_reg;
    logic [LNS_W-1:0]  lnr_mag_reg;
    logic [46:0]       qb_reg, qt_reg;
    logic [DIV_M-1:0]  inv_reg;
    logic [50:0]       q_reg;
    logic              c_neg_reg;
    logic [TEMP_W-1:0] temp_reg;
    logic              terr_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              eseen_reg;
    logic [TEMP_W-1:0] avg_reg;
    logic              mvalid_reg;
    logic [TEMP_W-1:0] mtemp_reg;
    logic              merr_reg;

    logic              div_start, div_done;
    logic [DIV_N-1:0]  div_a, div_q;
    logic [DIV_M-1:0]  div_b;

    ntca_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    // ln interpolation for both operands
    logic [PROD_W-1:0]  f_n, f_d, w_n, w_d;
    logic [LG:0]        ix_n, ix_d;
    logic [LN_W-1:0]    lo_n, hi_n, lo_d, hi_d;
    logic [59:0]        pr_n, pr_d;
    logic [LN_W-1:0]    fr_n, fr_d;
    logic [LNS_W-1:0]   ln_n, ln_d;
    logic [LNS_W:0]     lnr;
    logic               bad;
    logic [48:0]        inv;
    logic [52:0]        c_a;
    logic               c_neg;
    logic [52:0]        c_mag;
    logic               c_big;
    logic [44:0]        c_prod;
    logic [TEMP_W-1:0]  c_q;
    logic               out_free;
    logic               sum_neg;
    logic [SUM_W-1:0]   sum_mag;
    logic [SUM_W-1:0]   avg_in;
    logic [AVG_PW-1:0]  avg_prod;
    logic [TEMP_W-1:0]  avg_mag;
    logic [TEMP_W-1:0]  avg_q;

    always_comb begin
        f_n  = {num_reg[PROD_W-2:0], 1'b0};
        f_d  = {den_reg[PROD_W-2:0], 1'b0};
        ix_n = {1'b0, f_n[PROD_W-1 -: LG]};
        ix_d = {1'b0, f_d[PROD_W-1 -: LG]};
        w_n  = f_n << LG;
        w_d  = f_d << LG;
        lo_n = ln_rom[ix_n];
        hi_n = ln_rom[ix_n + 1'b1];
        lo_d = ln_rom[ix_d];
        hi_d = ln_rom[ix_d + 1'b1];
        pr_n = 60'(hi_n - lo_n) * 60'(w_n);
        pr_d = 60'(hi_d - lo_d) * 60'(w_d);
        fr_n = lo_n + pr_n[59:32];
        fr_d = lo_d + pr_d[59:32];
        ln_n = LNS_W'(5'd31 - ns_reg) * LNS_W'(ln_rom[LN_TABLE_DEPTH]) + LNS_W'(fn_reg);
        ln_d = LNS_W'(5'd31 - ds_reg) * LNS_W'(ln_rom[LN_TABLE_DEPTH]) + LNS_W'(fd_reg);
        lnr  = {1'b0, ln_n} - {1'b0, ln_d};

        bad = (code_reg == '0) || (code_reg == FULL_CODE) || (rs_reg == '0) ||
              (rn_reg == '0) || (beta_reg == '0) || (t0_reg == '0);

        inv = lnr_neg_reg ? ({2'b00, qt_reg} - {2'b00, qb_reg})
                          : ({2'b00, qt_reg} + {2'b00, qb_reg});

        c_a   = {2'b00, q_reg} - ZERO_C_Q;
        c_neg = c_a[52];
        c_mag = (c_neg ? (53'd0 - c_a) : c_a) + 53'd50;
        // anything at or above 2^22 saturates whatever its sign
        c_big  = |c_mag[52:22];
        c_prod = 45'(c_mag[21:0]) * 45'(RECIP100);
        c_q    = c_prod[44:RECIP100_SH];

        sum_neg  = sum_reg[SUM_W-1];
        sum_mag  = sum_neg ? (SUM_W'(0) - sum_reg) : sum_reg;
        avg_in   = sum_mag + SUM_W'(AVG_COUNT / 2);
        avg_prod = AVG_PW'(avg_in) * AVG_PW'(AVG_RECIP);
        avg_mag  = avg_prod[AVG_SH +: TEMP_W];
        avg_q    = sum_neg ? (TEMP_W'(0) - avg_mag) : avg_mag;

        out_free = !mvalid_reg || m_ready;
    end

    // divider operand select
    always_comb begin
        div_start = cmd.div_start;
        div_a     = '0;
        div_b     = '0;
        case (cmd.op)
            DP_DBETA: begin
                div_a = DIV_N'(lnr_mag_reg) << 12;
                div_b = DIV_M'(beta_reg);
            end
            DP_DT0: begin
                div_a = DIV_N'(100) << 40;
                div_b = DIV_M'(t0_reg);
            end
            DP_DQ: begin
                div_a = DIV_N'(1600) << 40;
                div_b = inv_reg;
            end
            default: begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_reg     <= RES_W'(10000);
            rn_reg     <= RES_W'(10000);
            beta_reg   <= BETA_W'(3950);
            t0_reg     <= T0_W'(29815);
            sum_reg    <= '0;
            cnt_reg    <= '0;
            eseen_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SERIES:  rs_reg   <= cfg_data;
                    CFG_NOMINAL: rn_reg   <= cfg_data;
                    CFG_BETA:    beta_reg <= cfg_data[BETA_W-1:0];
                    CFG_T0:      t0_reg   <= cfg_data[T0_W-1:0];
                    default:     rs_reg   <= rs_reg;
                endcase
            end
            // load a new result or drop the one just taken
            if ((cmd.op == DP_EMIT) && out_free) begin
                mvalid_reg <= 1'b1;
            end else if (mvalid_reg && m_ready) begin
                mvalid_reg <= 1'b0;
            end
            case (cmd.op)
                DP_LOAD: code_reg <= s_adc_code;
                DP_CHECK: begin
                    num_reg  <= PROD_W'(rs_reg) * PROD_W'(code_reg);
                    den_reg  <= PROD_W'(rn_reg) * PROD_W'(FULL_CODE - code_reg);
                    ns_reg   <= '0;
                    ds_reg   <= '0;
                    terr_reg <= bad;
                    temp_reg <= TEMP_MIN;
                end
                DP_NORM: begin
                    // shift each operand until its leading one reaches the top
                    if (!num_reg[PROD_W-1]) begin
                        num_reg <= num_reg << 1;
                        ns_reg  <= ns_reg + 1'b1;
                    end
                    if (!den_reg[PROD_W-1]) begin
                        den_reg <= den_reg << 1;
                        ds_reg  <= ds_reg + 1'b1;
                    end
                end
                DP_LN: begin
                    fn_reg <= fr_n;
                    fd_reg <= fr_d;
                end
                DP_LNDIFF: begin
                    lnr_neg_reg <= lnr[LNS_W];
                    lnr_mag_reg <= lnr[LNS_W] ? LNS_W'(~lnr + 1'b1) : lnr[LNS_W-1:0];
                end
                DP_DBETA: if (div_done) qb_reg <= div_q[46:0];
                DP_DT0:   if (div_done) qt_reg <= div_q[46:0];
                DP_INV: begin
                    inv_reg <= inv[DIV_M-1:0];
                    if (inv[48] || inv == '0) begin
                        terr_reg <= 1'b1;
                        temp_reg <= TEMP_MAX;
                    end
                end
                DP_DQ: if (div_done) q_reg <= div_q[50:0];
                DP_DC: begin
                    c_neg_reg <= c_neg;
                    q_reg     <= c_big ? 51'd65535 : 51'(c_q);
                end
                DP_TEMP: begin
                    // saturate to the 16-bit range
                    if (c_neg_reg) begin
                        if (q_reg > 51'd32768) begin
                            terr_reg <= 1'b1;
                            temp_reg <= TEMP_MIN;
                        end else begin
                            temp_reg <= TEMP_W'(51'd0 - q_reg);
                        end
                    end else begin
                        if (q_reg > 51'd32767) begin
                            terr_reg <= 1'b1;
                            temp_reg <= TEMP_MAX;
                        end else begin
                            temp_reg <= q_reg[TEMP_W-1:0];
                        end
                    end
                end
                DP_ACCUM: begin
                    sum_reg   <= sum_reg + SUM_W'($signed(temp_reg));
                    eseen_reg <= eseen_reg | terr_reg;
                    cnt_reg   <= cnt_reg + 1'b1;
                end
                DP_DAVG: avg_reg <= avg_q;
                DP_EMIT: begin
                    if (out_free) begin
                        mtemp_reg  <= avg_reg;
                        merr_reg   <= eseen_reg;
                        sum_reg    <= '0;
                        cnt_reg    <= '0;
                        eseen_reg  <= 1'b0;
                    end
                end
                default: code_reg <= code_reg;
            endcase
        end
    end

    always_comb begin
        sts.bad_in     = bad;
        sts.norm_done  = num_reg[PROD_W-1] && den_reg[PROD_W-1];
        sts.inv_bad    = inv[48] || (inv == '0);
        sts.div_done   = div_done;
        sts.group_full = (cnt_reg + 1'b1) == CNT_W'(AVG_COUNT);
        sts.out_free   = out_free;
    end

    assign m_valid        = mvalid_reg;
    assign m_average_temp = $signed(mtemp_reg);
    assign m_range_error  = merr_reg;

endmodule

`default_nettype wire

FILE: sv/ntca_ctrl.sv
// ---------------------------------------------------------------------------
// ntca_ctrl
// Sequencer: steps one sample through the datapath; mean at group end.
// ---------------------------------------------------------------------------
`default_nettype none

module ntca_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output ntca_pkg::dp_cmd_t       cmd,
    input  wire ntca_pkg::dp_sts_t  sts
);
    import ntca_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_NORM, ST_LN, ST_LNDIFF, ST_DBETA, ST_DT0, ST_INV,
        ST_DQ, ST_DC, ST_TEMP, ST_ACCUM, ST_DAVG, ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   first_reg;

    always_comb begin
        state_next    = state_reg;
        cmd.op        = DP_IDLE;
        cmd.div_start = 1'b0;
        s_ready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.op     = DP_CHECK;
                state_next = sts.bad_in ? ST_ACCUM : ST_NORM;
            end
            ST_NORM: begin
                cmd.op = DP_NORM;
                if (sts.norm_done) state_next = ST_LN;
            end
            ST_LN: begin
                cmd.op     = DP_LN;
                state_next = ST_LNDIFF;
            end
            ST_LNDIFF: begin
                cmd.op     = DP_LNDIFF;
                state_next = ST_DBETA;
            end
            ST_DBETA: begin
                cmd.op        = DP_DBETA;
                cmd.div_start = first_reg;
                if (sts.div_done) state_next = ST_DT0;
            end
            ST_DT0: begin
                cmd.op        = DP_DT0;
                cmd.div_start = first_reg;
                if (sts.div_done) state_next = ST_INV;
            end
            ST_INV: begin
                cmd.op     = DP_INV;
                state_next = sts.inv_bad ? ST_ACCUM : ST_DQ;
            end
            ST_DQ: begin
                cmd.op        = DP_DQ;
                cmd.div_start = first_reg;
                if (sts.div_done) state_next = ST_DC;
            end
            ST_DC: begin
                cmd.op     = DP_DC;
                state_next = ST_TEMP;
            end
            ST_TEMP: begin
                cmd.op     = DP_TEMP;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.op     = DP_ACCUM;
                state_next = sts.group_full ? ST_DAVG : ST_IDLE;
            end
            ST_DAVG: begin
                cmd.op     = DP_DAVG;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.op = DP_EMIT;
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            first_reg <= (state_next != state_reg);
        end
    end

endmodule

`default_nettype wire

FILE: sv/ntc_thermistor_temp_averager.sv
// ---------------------------------------------------------------------------
// ntc_thermistor_temp_averager
// NTC thermistor reading to temperature (Beta equation, table ln) with a
// rounded mean over each group of AVG_COUNT samples.
// ---------------------------------------------------------------------------
//
//  Channel  | Ports                                   | Transfer when
//  ---------+-----------------------------------------+--------------------
//  input    | s_valid s_ready s_adc_code              | s_valid & s_ready
//  result   | m_valid m_ready m_average_temp          | m_valid & m_ready
//           | m_range_error                           |
//  config   | cfg_valid cfg_ready cfg_index cfg_data  | cfg_valid & cfg_ready
//
//  Each sample runs normalising shifts for the ln step, then three 52-bit
//  quotients from the one serial divider. An extreme code or a zero
//  register skips to the accumulate step; the last sample of a group
//  adds the mean step and the result register load.
//  Reset restores the register defaults and clears the group accumulator.
//  A result waiting on m_ready stalls only the next group's final step.
// ---------------------------------------------------------------------------
`default_nettype none

module ntc_thermistor_temp_averager #(
    parameter int AVG_COUNT      = 5,
    parameter int LN_TABLE_DEPTH = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [ntca_pkg::CODE_W-1:0]      s_adc_code,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [ntca_pkg::TEMP_W-1:0]    m_average_temp,
    output logic                                  m_range_error,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ntca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ntca_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ntca_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequence one sample at a time
    ntca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // arithmetic, registers and the result holding stage
    ntca_datapath #(
        .AVG_COUNT      (AVG_COUNT),
        .LN_TABLE_DEPTH (LN_TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_adc_code     (s_adc_code),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average_temp (m_average_temp),
        .m_range_error  (m_range_error)
    );

    // hold off the next input until the current sample has been processed
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a sample is in progress");

    // a new result only appears at the end of a sample's processing
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised without a sample being processed");

endmodule

`default_nettype wire
